@@ rtl/scr_pkg.sv @@
// shared types, constants and the s-curve table for the stepper ramp controller
package scr_pkg;

  localparam int CURVE_DEPTH = 256;
  localparam int CURVE_IDX_W = $clog2(CURVE_DEPTH);
  localparam int MIN_RAMP_MS = 100;
  localparam int FREQ_W      = 13;
  localparam int HP_W        = 19;
  localparam int LEN_W       = 14;
  localparam int HOLD_W      = 10;
  localparam int START_W     = 9;
  localparam int RT_W        = 14;
  localparam int FRAC_W      = 16;
  localparam int CURVE_W     = FRAC_W + 1;
  localparam int POS_W       = CURVE_IDX_W + FRAC_W;
  localparam int DIV_NUM_W   = POS_W + LEN_W;
  localparam int DIV_DEN_W   = LEN_W;
  localparam int PROD_W      = FREQ_W + CURVE_W;
  localparam int HALF_US     = 500000;
  localparam int LEN_SAT     = (1 << LEN_W) - 1;
  localparam int HOLD_SAT    = (1 << HOLD_W) - 1;
  localparam int PADDR_W     = 4;
  localparam int PDATA_W     = 32;

  localparam longint unsigned PI_Q28 = 64'd843314857;

  // reciprocals of the taylor divisors (2k)(2k+1), exact for terms below 2^31
  localparam int RCP_SH = 40;
  localparam longint unsigned TAYLOR_RCP [1:7] = '{
    ((64'd1 << RCP_SH) + 64'd5) / 64'd6,
    ((64'd1 << RCP_SH) + 64'd19) / 64'd20,
    ((64'd1 << RCP_SH) + 64'd41) / 64'd42,
    ((64'd1 << RCP_SH) + 64'd71) / 64'd72,
    ((64'd1 << RCP_SH) + 64'd109) / 64'd110,
    ((64'd1 << RCP_SH) + 64'd155) / 64'd156,
    ((64'd1 << RCP_SH) + 64'd209) / 64'd210
  };

  typedef enum logic [1:0] {
    FN_TICK  = 2'd0,
    FN_SPEED = 2'd1,
    FN_DIR   = 2'd2,
    FN_STOP  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_NONE        = 3'd0,
    ST_SPEED_OK    = 3'd1,
    ST_DIR_OK      = 3'd2,
    ST_DIR_PENDING = 3'd3,
    ST_STOPPED     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    REG_START_FREQ = 2'd0,
    REG_MAX_FREQ   = 2'd1,
    REG_RAMP_TIME  = 2'd2,
    REG_HOLD       = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_TICK_INC,
    OP_RAMP_SPEED,
    OP_RAMP_STOP,
    OP_DIR,
    OP_FINISH_RAMP,
    OP_POS_DIV,
    OP_CURVE,
    OP_SCALE,
    OP_SETF_CURVE,
    OP_RAMP_REV,
    OP_HOLD_ENTER,
    OP_FLIP,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    DIV_HP,
    DIV_LEN,
    DIV_POS
  } div_tgt_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_ADV,
    S_WAIT_POS,
    S_SCALE,
    S_NEWF,
    S_WAIT_REV,
    S_REV,
    S_WAIT_OUT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [START_W-1:0] start_freq;
    logic [FREQ_W-1:0]  max_freq;
    logic [RT_W-1:0]    ramp_time_ms;
    logic [HOLD_W-1:0]  hold_ms;
  } cfg_t;

  typedef struct packed {
    op_t op;
  } ctrl_cmd_t;

  typedef struct packed {
    func_t func;
    logic  ramp_on;
    logic  ramp_done;
    logic  dir_pending;
    logic  holding;
    logic  cur_gt_start;
    logic  hold_done;
    logic  div_busy;
    logic  out_free;
  } dp_status_t;

  typedef logic [CURVE_W-1:0] curve_tab_t [0:CURVE_DEPTH];

  // raised-cosine table, sin^2 in q28 by taylor series, rounded to q1.16
  function automatic curve_tab_t build_curve();
    curve_tab_t      t;
    longint unsigned x;
    longint unsigned term;
    longint unsigned sq;
    longint unsigned v;
    longint          sum;
    logic [127:0]    wide;
    for (int i = 0; i < CURVE_DEPTH; i++) begin
      x    = (PI_Q28 * longint'(i) + longint'(CURVE_DEPTH)) >> (CURVE_IDX_W + 1);
      term = x;
      sum  = longint'(x);
      for (int k = 1; k <= 7; k++) begin
        term = (term * x) >> 28;
        wide = 128'((term * x) >> 28) * 128'(TAYLOR_RCP[k]);
        term = 64'(wide >> RCP_SH);
        if (k[0]) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      if (sum > (longint'(1) << 28)) sum = longint'(1) << 28;
      sq = longint'(sum) * longint'(sum);
      v  = (sq + (longint'(1) << 39)) >> 40;
      if (v > 65535) v = 65535;
      t[i] = CURVE_W'(v);
    end
    t[0]           = '0;
    t[CURVE_DEPTH] = CURVE_W'(1 << FRAC_W);
    return t;
  endfunction

  localparam curve_tab_t CURVE_TAB = build_curve();

endpackage

@@ rtl/scr_in_if.sv @@
// input channel: command beat with valid/ready handshake
interface scr_in_if import scr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        func;
  logic [FREQ_W-1:0] speed_hz;
  logic              dir_fwd;

  modport source (output valid, output func, output speed_hz, output dir_fwd, input ready);
  modport sink (input valid, input func, input speed_hz, input dir_fwd, output ready);
endinterface

@@ rtl/scr_out_if.sv @@
// output channel: result beat with valid/ready handshake
interface scr_out_if import scr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FREQ_W-1:0] freq_hz;
  logic [HP_W-1:0]   half_period_us;
  logic              pulse_on;
  logic              dir_out;
  logic              ramping;
  logic [2:0]        status;

  modport source (output valid, output freq_hz, output half_period_us, output pulse_on,
                  output dir_out, output ramping, output status, input ready);
  modport sink (input valid, input freq_hz, input half_period_us, input pulse_on,
                input dir_out, input ramping, input status, output ready);
endinterface

@@ rtl/scr_div.sv @@
// shared restoring divider, one quotient bit per cycle
module scr_div import scr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic                 busy,
  output logic                 done,
  output logic [DIV_NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(DIV_NUM_W + 1);

  logic [DIV_NUM_W-1:0] acc;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] dvs;
  logic [CNT_W-1:0]     cnt;
  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   diff;
  logic                 ge;
  logic [DIV_DEN_W-1:0] rem_next;

  always_comb begin
    trial    = {rem, acc[DIV_NUM_W-1]};
    diff     = trial - {1'b0, dvs};
    ge       = trial >= {1'b0, dvs};
    rem_next = ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= num;
      rem <= '0;
      dvs <= den;
    end else if (busy) begin
      acc <= {acc[DIV_NUM_W-2:0], ge};
      rem <= rem_next;
    end
  end

  assign quo = acc;

endmodule

@@ rtl/scr_dp.sv @@
// datapath: motion state, ramp arithmetic, curve lookup and result register
module scr_dp import scr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  ctrl_cmd_t         cmd,
  output dp_status_t        st,
  input  logic [1:0]        in_func,
  input  logic [FREQ_W-1:0] in_speed,
  input  logic              in_dir,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [FREQ_W-1:0] out_freq,
  output logic [HP_W-1:0]   out_hp,
  output logic              out_pulse,
  output logic              out_dir,
  output logic              out_ramping,
  output logic [2:0]        out_status
);

  func_t               item_func;
  logic [FREQ_W-1:0]   item_speed;
  logic                item_dir;
  logic [FREQ_W-1:0]   cur_freq;
  logic [HP_W-1:0]     half_period;
  logic [FREQ_W-1:0]   ramp_from;
  logic [FREQ_W-1:0]   ramp_to;
  logic [LEN_W-1:0]    ramp_elapsed;
  logic [LEN_W-1:0]    ramp_length;
  logic                ramp_on;
  logic                dir_now;
  logic                dir_wanted;
  logic                dir_pending;
  logic                holding;
  logic [HOLD_W-1:0]   hold_elapsed;
  logic [POS_W-1:0]    pos;
  logic [CURVE_W-1:0]  s_val;
  logic [PROD_W-1:0]   prod;
  status_t             status_r;
  div_tgt_t            div_tgt;

  logic [FREQ_W-1:0]    start_ext;
  logic [FREQ_W-1:0]    speed_tgt;
  logic                 setf_go;
  logic [FREQ_W-1:0]    setf_in;
  logic [FREQ_W-1:0]    setf_val;
  logic                 ramp_go;
  logic [FREQ_W-1:0]    ramp_tgt;
  logic [FREQ_W-1:0]    change;
  logic                 max_gt_start;
  logic [FREQ_W-1:0]    range_w;
  logic                 div_start;
  div_tgt_t             div_sel;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic                 div_busy;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] div_quo;
  logic [CURVE_IDX_W-1:0] idx;
  logic [CURVE_IDX_W:0]   idx_hi;
  logic [CURVE_W-1:0]   t_lo;
  logic [CURVE_W-1:0]   t_hi;
  logic [CURVE_W+FRAC_W-1:0] interp;
  logic [CURVE_W-1:0]   s_calc;
  logic [FREQ_W-1:0]    span;
  logic [PROD_W:0]      prod_up;
  logic [FREQ_W-1:0]    curve_f;
  logic [LEN_W-1:0]     len_clamped;

  always_comb begin
    start_ext    = FREQ_W'(cfg.start_freq);
    max_gt_start = cfg.max_freq > start_ext;
    range_w      = cfg.max_freq - start_ext;

    if (item_speed == '0) speed_tgt = '0;
    else if (item_speed < start_ext) speed_tgt = start_ext;
    else if (item_speed > cfg.max_freq) speed_tgt = cfg.max_freq;
    else speed_tgt = item_speed;

    // curve interpolation
    idx    = pos[POS_W-1:FRAC_W];
    idx_hi = {1'b0, idx} + 1'b1;
    t_lo   = CURVE_TAB[idx];
    t_hi   = CURVE_TAB[idx_hi];
    interp = (t_hi - t_lo) * pos[FRAC_W-1:0];
    s_calc = t_lo + interp[CURVE_W+FRAC_W-1:FRAC_W];

    span    = (ramp_to >= ramp_from) ? ramp_to - ramp_from : ramp_from - ramp_to;
    prod_up = {1'b0, prod} + (PROD_W+1)'((1 << FRAC_W) - 1);
    if (ramp_to >= ramp_from) curve_f = ramp_from + prod[FREQ_W+FRAC_W-1:FRAC_W];
    else curve_f = ramp_from - prod_up[FREQ_W+FRAC_W-1:FRAC_W];

    setf_go = 1'b0;
    setf_in = ramp_to;
    case (cmd.op)
      OP_FINISH_RAMP: begin
        setf_go = 1'b1;
        setf_in = ramp_to;
      end
      OP_SETF_CURVE: begin
        setf_go = 1'b1;
        setf_in = curve_f;
      end
      OP_HOLD_ENTER: begin
        setf_go = 1'b1;
        setf_in = start_ext;
      end
      default: setf_go = 1'b0;
    endcase
    setf_val = (setf_in > cfg.max_freq) ? cfg.max_freq : setf_in;

    ramp_go  = 1'b0;
    ramp_tgt = '0;
    case (cmd.op)
      OP_RAMP_SPEED: begin
        ramp_go  = 1'b1;
        ramp_tgt = speed_tgt;
      end
      OP_RAMP_STOP: begin
        ramp_go  = 1'b1;
        ramp_tgt = '0;
      end
      OP_RAMP_REV: begin
        ramp_go  = 1'b1;
        ramp_tgt = start_ext;
      end
      default: ramp_go = 1'b0;
    endcase
    change = (ramp_tgt > cur_freq) ? ramp_tgt - cur_freq : cur_freq - ramp_tgt;

    div_start = 1'b0;
    div_sel   = DIV_HP;
    div_num   = DIV_NUM_W'(HALF_US);
    div_den   = DIV_DEN_W'(setf_val);
    if (setf_go && setf_val != '0) begin
      div_start = 1'b1;
    end else if (ramp_go && max_gt_start) begin
      div_start = 1'b1;
      div_sel   = DIV_LEN;
      div_num   = DIV_NUM_W'(cfg.ramp_time_ms) * DIV_NUM_W'(change);
      div_den   = DIV_DEN_W'(range_w);
    end else if (cmd.op == OP_POS_DIV) begin
      div_start = 1'b1;
      div_sel   = DIV_POS;
      div_num   = {ramp_elapsed, POS_W'(0)};
      div_den   = ramp_length;
    end

    if (div_quo < DIV_NUM_W'(MIN_RAMP_MS)) len_clamped = LEN_W'(MIN_RAMP_MS);
    else if (div_quo > DIV_NUM_W'(LEN_SAT)) len_clamped = LEN_W'(LEN_SAT);
    else len_clamped = div_quo[LEN_W-1:0];
  end

  scr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_freq     <= '0;
      half_period  <= '0;
      ramp_from    <= '0;
      ramp_to      <= '0;
      ramp_elapsed <= '0;
      ramp_length  <= '0;
      ramp_on      <= 1'b0;
      dir_now      <= 1'b1;
      dir_wanted   <= 1'b1;
      dir_pending  <= 1'b0;
      holding      <= 1'b0;
      hold_elapsed <= '0;
      status_r     <= ST_NONE;
      div_tgt      <= DIV_HP;
      out_valid    <= 1'b0;
    end else begin
      if (div_start) div_tgt <= div_sel;
      if (div_done) begin
        case (div_tgt)
          DIV_HP:  half_period <= div_quo[HP_W-1:0];
          DIV_LEN: ramp_length <= len_clamped;
          DIV_POS: pos         <= div_quo[POS_W-1:0];
          default: pos         <= div_quo[POS_W-1:0];
        endcase
      end

      if (setf_go) begin
        cur_freq <= setf_val;
        if (setf_val == '0) half_period <= '0;
      end

      if (ramp_go) begin
        ramp_from    <= cur_freq;
        ramp_to      <= ramp_tgt;
        ramp_elapsed <= '0;
        ramp_on      <= 1'b1;
        if (!max_gt_start) ramp_length <= cfg.ramp_time_ms;
      end

      if (out_valid && out_ready && cmd.op != OP_EMIT) out_valid <= 1'b0;

      case (cmd.op)
        OP_LOAD: status_r <= ST_NONE;
        OP_TICK_INC: begin
          if (ramp_on && ramp_elapsed != LEN_W'(LEN_SAT)) ramp_elapsed <= ramp_elapsed + 1'b1;
          if (holding && hold_elapsed != HOLD_W'(HOLD_SAT)) hold_elapsed <= hold_elapsed + 1'b1;
        end
        OP_RAMP_SPEED: status_r <= ST_SPEED_OK;
        OP_RAMP_STOP: begin
          dir_pending <= 1'b0;
          holding     <= 1'b0;
          status_r    <= ST_STOPPED;
        end
        OP_DIR: begin
          dir_wanted <= item_dir;
          if (item_dir != dir_now) begin
            dir_pending <= 1'b1;
            status_r    <= ST_DIR_PENDING;
          end else begin
            status_r <= ST_DIR_OK;
          end
        end
        OP_FINISH_RAMP: ramp_on <= 1'b0;
        OP_HOLD_ENTER: begin
          holding      <= 1'b1;
          hold_elapsed <= '0;
        end
        OP_FLIP: begin
          dir_now     <= dir_wanted;
          dir_pending <= 1'b0;
          holding     <= 1'b0;
          status_r    <= ST_DIR_OK;
        end
        OP_EMIT: out_valid <= 1'b1;
        default: status_r <= status_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      item_func  <= func_t'(in_func);
      item_speed <= in_speed;
      item_dir   <= in_dir;
    end
    if (cmd.op == OP_CURVE) s_val <= s_calc;
    if (cmd.op == OP_SCALE) prod <= span * s_val;
    if (cmd.op == OP_EMIT) begin
      out_freq    <= cur_freq;
      out_hp      <= half_period;
      out_pulse   <= cur_freq != '0;
      out_dir     <= dir_now;
      out_ramping <= ramp_on;
      out_status  <= status_r;
    end
  end

  always_comb begin
    st.func         = item_func;
    st.ramp_on      = ramp_on;
    st.ramp_done    = ramp_elapsed >= ramp_length;
    st.dir_pending  = dir_pending;
    st.holding      = holding;
    st.cur_gt_start = cur_freq > start_ext;
    st.hold_done    = hold_elapsed >= cfg.hold_ms;
    st.div_busy     = div_busy | div_done;
    st.out_free     = !out_valid || out_ready;
  end

  a_hold_needs_pending: assert property (@(posedge clk) disable iff (rst)
    holding |-> dir_pending) else $error("hold without a pending reversal");
  a_div_single: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy) else $error("divider restarted while busy");
  a_period_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_freq == '0) == (out_hp == '0)))
    else $error("half period disagrees with frequency");

endmodule

@@ rtl/scr_ctrl.sv @@
// controller: sequences one beat through the datapath operations
module scr_ctrl import scr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t st,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    in_ready   = state == S_IDLE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (st.func)
          FN_TICK: begin
            cmd.op     = OP_TICK_INC;
            state_next = S_ADV;
          end
          FN_SPEED: begin
            cmd.op     = OP_RAMP_SPEED;
            state_next = S_WAIT_OUT;
          end
          FN_DIR: begin
            cmd.op     = OP_DIR;
            state_next = S_OUT;
          end
          FN_STOP: begin
            cmd.op     = OP_RAMP_STOP;
            state_next = S_WAIT_OUT;
          end
          default: state_next = S_OUT;
        endcase
      end
      S_ADV: begin
        if (!st.ramp_on) begin
          state_next = S_REV;
        end else if (st.ramp_done) begin
          cmd.op     = OP_FINISH_RAMP;
          state_next = S_WAIT_REV;
        end else begin
          cmd.op     = OP_POS_DIV;
          state_next = S_WAIT_POS;
        end
      end
      S_WAIT_POS: begin
        if (!st.div_busy) begin
          cmd.op     = OP_CURVE;
          state_next = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd.op     = OP_SCALE;
        state_next = S_NEWF;
      end
      S_NEWF: begin
        cmd.op     = OP_SETF_CURVE;
        state_next = S_WAIT_REV;
      end
      S_WAIT_REV: begin
        if (!st.div_busy) state_next = S_REV;
      end
      S_REV: begin
        state_next = S_OUT;
        if (st.dir_pending) begin
          if (st.cur_gt_start && !st.holding) begin
            if (!st.ramp_on) begin
              cmd.op     = OP_RAMP_REV;
              state_next = S_WAIT_OUT;
            end
          end else if (!st.ramp_on) begin
            if (!st.holding) begin
              cmd.op     = OP_HOLD_ENTER;
              state_next = S_WAIT_OUT;
            end else if (st.hold_done) begin
              cmd.op = OP_FLIP;
            end
          end
        end
      end
      S_WAIT_OUT: begin
        if (!st.div_busy) state_next = S_OUT;
      end
      S_OUT: begin
        if (st.out_free) begin
          cmd.op     = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_emit_settled: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_EMIT) |-> !st.div_busy) else $error("result sent with divide in flight");
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !st.div_busy) else $error("divider busy while idle");

endmodule

@@ rtl/stepper_scurve_ramp_controller.sv @@
// top level: apb register file, controller and datapath of the s-curve ramp generator
//
//  channel  dir  handshake            payload
//  in_ch    in   valid/ready          func, speed_hz, dir_fwd
//  out_ch   out  valid/ready          freq_hz, half_period_us, pulse_on, dir_out, ramping, status
//  apb      in   psel/penable/pready  paddr, pwdata, prdata
//
// a direction beat runs no divide; a speed or stop beat runs at most one (the ramp length divide)
// a tick runs at most two divides on the shared divider
// the next beat is taken while a finished result waits in the output register
// rst is synchronous; registers return to 100 / 3000 / 1000 / 100
module stepper_scurve_ramp_controller import scr_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  scr_in_if.sink              in_ch,
  scr_out_if.source           out_ch,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t st;
  reg_idx_t   reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_freq   <= START_W'(100);
      cfg.max_freq     <= FREQ_W'(3000);
      cfg.ramp_time_ms <= RT_W'(1000);
      cfg.hold_ms      <= HOLD_W'(100);
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_START_FREQ: cfg.start_freq   <= pwdata[START_W-1:0];
        REG_MAX_FREQ:   cfg.max_freq     <= pwdata[FREQ_W-1:0];
        REG_RAMP_TIME:  cfg.ramp_time_ms <= pwdata[RT_W-1:0];
        REG_HOLD:       cfg.hold_ms      <= pwdata[HOLD_W-1:0];
        default:        cfg.hold_ms      <= cfg.hold_ms;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_START_FREQ: prdata = PDATA_W'(cfg.start_freq);
      REG_MAX_FREQ:   prdata = PDATA_W'(cfg.max_freq);
      REG_RAMP_TIME:  prdata = PDATA_W'(cfg.ramp_time_ms);
      REG_HOLD:       prdata = PDATA_W'(cfg.hold_ms);
      default:        prdata = '0;
    endcase
  end

  scr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  scr_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .st          (st),
    .in_func     (in_ch.func),
    .in_speed    (in_ch.speed_hz),
    .in_dir      (in_ch.dir_fwd),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_freq    (out_ch.freq_hz),
    .out_hp      (out_ch.half_period_us),
    .out_pulse   (out_ch.pulse_on),
    .out_dir     (out_ch.dir_out),
    .out_ramping (out_ch.ramping),
    .out_status  (out_ch.status)
  );

endmodule
